// ===== rtl/core/lrupr_pkg.sv =====
// lrupr_pkg: shared types and constants for the lru page replacement block
// used by lrupr_cell and lru_page_replacement; depends on nothing

`default_nettype none

package lrupr_pkg;

    // default geometry
    localparam int FRAMES_DEFAULT    = 8;
    localparam int PAGE_BITS_DEFAULT = 16;

    // fixed field widths
    localparam int CFG_W       = 4;
    localparam int IDX_OUT_W   = 3;
    localparam int FAULT_W     = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } lrupr_state_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic look;     // lookup cycle: cells latch their selection
        logic commit;   // update cycle: cells write page and rank
        logic hit_any;  // some active frame matched
        logic fresh;    // miss that fills a free frame
        logic evict;    // miss with all active frames in use
    } lrupr_ctrl_t;

    // status from one cell back to the sequencer
    typedef struct packed {
        logic valid;      // frame holds a page
        logic hit_first;  // lowest-index match in the chain
        logic fill_cand;  // first free frame and active
        logic chosen;     // frame takes the reference this cycle
        logic victim;     // frame is evicted this cycle
    } lrupr_stat_t;

endpackage : lrupr_pkg

`default_nettype wire

// ===== rtl/core/lrupr_rank_find.sv =====
// lrupr_rank_find: finds the largest recency rank present among active frames
// depends on nothing beyond its parameters

`default_nettype none

module lrupr_rank_find #(
    parameter int FRAMES = 8,
    parameter int AGE_W  = 3
) (
    input  wire logic [FRAMES-1:0] rank_present,
    output logic      [AGE_W-1:0]  max_rank
);

    // highest set bit of the rank map
    always_comb begin
        max_rank = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (rank_present[i]) begin
                max_rank = AGE_W'(i);
            end
        end
    end

endmodule : lrupr_rank_find

`default_nettype wire

// ===== rtl/core/lrupr_cell.sv =====
// lrupr_cell: one frame of the table, holding its page, rank and filled flag
// depends on lrupr_pkg; chained to its neighbors for hit priority and fill order

`default_nettype none

module lrupr_cell #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int AGE_W     = 3
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire lrupr_pkg::lrupr_ctrl_t ctrl,
    input  wire logic [PAGE_BITS-1:0]   req_page,
    input  wire logic [AGE_W-1:0]       ref_age,
    input  wire logic                   active,
    input  wire logic                   hit_in,
    input  wire logic                   prev_valid,
    output logic                        hit_out,
    output lrupr_pkg::lrupr_stat_t      stat,
    output logic [AGE_W-1:0]            age,
    output logic [PAGE_BITS-1:0]        page,
    output logic [FRAMES-1:0]           rank_onehot
);

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(FRAMES - 1);

    logic [PAGE_BITS-1:0] page_reg;
    logic [AGE_W-1:0]     age_reg, age_next;
    logic                 valid_reg, valid_next;
    logic                 hit_sel_reg, hit_sel_next;
    logic                 fill_sel_reg, fill_sel_next;
    logic                 match, first, fill_cand, fill, victim, chosen;

    // lookup: compare and pass hit priority to the right
    assign match     = valid_reg & active & (page_reg == req_page);
    assign first     = match & ~hit_in;
    assign hit_out   = hit_in | match;
    assign fill_cand = ~valid_reg & prev_valid & active;

    // update: which frame takes the reference
    assign fill   = fill_sel_reg & ctrl.fresh;
    assign victim = ctrl.evict & active & valid_reg & (age_reg == ref_age);
    assign chosen = hit_sel_reg | fill | victim;

    // next rank and flags
    always_comb begin
        age_next      = age_reg;
        valid_next    = valid_reg;
        hit_sel_next  = hit_sel_reg;
        fill_sel_next = fill_sel_reg;
        if (ctrl.look) begin
            hit_sel_next  = first;
            fill_sel_next = fill_cand;
        end
        if (ctrl.commit) begin
            if (chosen) begin
                age_next   = '0;
                valid_next = 1'b1;
            end else if (valid_reg && (ctrl.fresh || age_reg < ref_age) &&
                         age_reg < AGE_MAX) begin
                age_next = age_reg + AGE_W'(1);
            end
        end
    end

    // rank and flag registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reg      <= '0;
            valid_reg    <= 1'b0;
            hit_sel_reg  <= 1'b0;
            fill_sel_reg <= 1'b0;
        end else begin
            age_reg      <= age_next;
            valid_reg    <= valid_next;
            hit_sel_reg  <= hit_sel_next;
            fill_sel_reg <= fill_sel_next;
        end
    end

    // page store, written on a miss that lands here
    always_ff @(posedge aclk) begin
        if (ctrl.commit && chosen && !ctrl.hit_any) begin
            page_reg <= req_page;
        end
    end

    assign stat.valid     = valid_reg;
    assign stat.hit_first = first;
    assign stat.fill_cand = fill_cand;
    assign stat.chosen    = chosen;
    assign stat.victim    = victim;
    assign age            = age_reg;
    assign page           = page_reg;
    assign rank_onehot    = (valid_reg && active) ? (FRAMES'(1) << age_reg) : '0;

endmodule : lrupr_cell

`default_nettype wire

// ===== rtl/core/lru_page_replacement.sv =====
// lru_page_replacement: top level, sequencer, config register and result register
// depends on lrupr_pkg, lrupr_cell and lrupr_rank_find

// Fully associative LRU frame table built as a row of frame cells. Each page word
// goes through a lookup cycle in which every cell compares the page, the
// lowest-index hit ripples along the row and the largest active rank is found, and
// an update cycle in which the chosen frame is written and the ranks are aged.
// A new word is accepted in the update cycle of the previous one, provided the
// result register is free; a result that is not taken holds the update cycle
// until the downstream side frees the register.
// frames_in_use (1 to FRAMES; 0 acts as 1, larger values as FRAMES) may only be
// written while the block is idle. Frames beyond the active set keep their pages.

`default_nettype none

module lru_page_replacement #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEFAULT,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lrupr_pkg::CFG_W-1:0]     cfg_data,
    // page reference channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [PAGE_BITS-1:0]            s_page_number,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_hit,
    output logic [lrupr_pkg::IDX_OUT_W-1:0]      m_frame_index,
    output logic                                 m_evicted_valid,
    output logic [PAGE_BITS-1:0]                 m_evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]        m_faults_so_far
);

    localparam int AGE_W = $clog2(FRAMES);

    lrupr_pkg::lrupr_state_t state_reg, state_next;
    lrupr_pkg::lrupr_ctrl_t  ctrl;
    lrupr_pkg::lrupr_stat_t  stat [FRAMES];

    logic [lrupr_pkg::CFG_W-1:0]   frames_reg;
    logic [PAGE_BITS-1:0]          page_reg;
    logic                          hit_any_reg, hit_any_next;
    logic                          fill_any_reg, fill_any_next;
    logic [AGE_W-1:0]              ref_age_reg, ref_age_next;
    logic [lrupr_pkg::FAULT_W-1:0] fault_reg, fault_next;

    logic                          m_valid_reg, m_valid_next;
    logic                          m_hit_reg;
    logic [lrupr_pkg::IDX_OUT_W-1:0] m_index_reg;
    logic                          m_ev_valid_reg;
    logic [PAGE_BITS-1:0]          m_ev_page_reg;
    logic [lrupr_pkg::FAULT_W-1:0] m_fault_reg;

    logic [FRAMES:0]     hit_chain;
    logic [FRAMES-1:0]   active;
    logic [FRAMES-1:0]   valid_vec, chosen_vec, victim_vec;
    logic [AGE_W-1:0]    cell_age [FRAMES];
    logic [PAGE_BITS-1:0] cell_page [FRAMES];
    logic [FRAMES-1:0]   cell_rank [FRAMES];
    logic [FRAMES-1:0]   rank_present;
    logic [AGE_W-1:0]    max_rank, hit_age;
    logic [31:0]         chosen_idx;
    logic [PAGE_BITS-1:0] ev_page;
    logic                fill_any;
    logic                look, commit, out_free;
    int                  n_eff;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= lrupr_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            frames_reg <= cfg_data;
        end
    end

    // active frame set, clamped to 1..FRAMES
    always_comb begin
        n_eff = int'(frames_reg);
        if (n_eff < 1) begin
            n_eff = 1;
        end
        if (n_eff > FRAMES) begin
            n_eff = FRAMES;
        end
        for (int j = 0; j < FRAMES; j++) begin
            active[j] = (j < n_eff);
        end
    end

    // sequencer
    assign out_free = ~m_valid_reg | m_ready;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        look       = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            lrupr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = lrupr_pkg::ST_LOOK;
                end
            end
            lrupr_pkg::ST_LOOK: begin
                look       = 1'b1;
                state_next = lrupr_pkg::ST_UPDATE;
            end
            lrupr_pkg::ST_UPDATE: begin
                if (out_free) begin
                    commit     = 1'b1;
                    s_ready    = 1'b1;
                    state_next = s_valid ? lrupr_pkg::ST_LOOK : lrupr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lrupr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrupr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // request word capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            page_reg <= s_page_number;
        end
    end

    // broadcast to the cells
    assign ctrl.look    = look;
    assign ctrl.commit  = commit;
    assign ctrl.hit_any = hit_any_reg;
    assign ctrl.fresh   = ~hit_any_reg & fill_any_reg;
    assign ctrl.evict   = ~hit_any_reg & ~fill_any_reg;

    // row of frame cells
    assign hit_chain[0] = 1'b0;

    for (genvar j = 0; j < FRAMES; j++) begin : g_cell
        lrupr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .AGE_W     (AGE_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .req_page    (page_reg),
            .ref_age     (ref_age_reg),
            .active      (active[j]),
            .hit_in      (hit_chain[j]),
            .prev_valid  ((j == 0) ? 1'b1 : valid_vec[(j == 0) ? 0 : j-1]),
            .hit_out     (hit_chain[j+1]),
            .stat        (stat[j]),
            .age         (cell_age[j]),
            .page        (cell_page[j]),
            .rank_onehot (cell_rank[j])
        );

        assign valid_vec[j]  = stat[j].valid;
        assign chosen_vec[j] = stat[j].chosen;
        assign victim_vec[j] = stat[j].victim;
    end

    // gather cell status
    always_comb begin
        hit_age      = '0;
        rank_present = '0;
        fill_any     = 1'b0;
        chosen_idx   = '0;
        ev_page      = '0;
        for (int j = 0; j < FRAMES; j++) begin
            if (stat[j].hit_first) begin
                hit_age = hit_age | cell_age[j];
            end
            if (stat[j].chosen) begin
                chosen_idx = chosen_idx | 32'(j);
            end
            if (stat[j].victim) begin
                ev_page = ev_page | cell_page[j];
            end
            fill_any     = fill_any | stat[j].fill_cand;
            rank_present = rank_present | cell_rank[j];
        end
    end

    lrupr_rank_find #(
        .FRAMES (FRAMES),
        .AGE_W  (AGE_W)
    ) u_rank_find (
        .rank_present (rank_present),
        .max_rank     (max_rank)
    );

    // lookup results held for the update cycle
    always_comb begin
        hit_any_next  = hit_any_reg;
        fill_any_next = fill_any_reg;
        ref_age_next  = ref_age_reg;
        if (look) begin
            hit_any_next  = hit_chain[FRAMES];
            fill_any_next = fill_any;
            ref_age_next  = hit_chain[FRAMES] ? hit_age : max_rank;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_any_reg  <= 1'b0;
            fill_any_reg <= 1'b0;
            ref_age_reg  <= '0;
        end else begin
            hit_any_reg  <= hit_any_next;
            fill_any_reg <= fill_any_next;
            ref_age_reg  <= ref_age_next;
        end
    end

    // saturating fault count
    always_comb begin
        fault_next = fault_reg;
        if (commit && !hit_any_reg && fault_reg != lrupr_pkg::FAULT_MAX) begin
            fault_next = fault_reg + lrupr_pkg::FAULT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg <= '0;
        end else begin
            fault_reg <= fault_next;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_hit_reg      <= hit_any_reg;
            m_index_reg    <= chosen_idx[lrupr_pkg::IDX_OUT_W-1:0];
            m_ev_valid_reg <= ctrl.evict;
            m_ev_page_reg  <= ev_page;
            m_fault_reg    <= fault_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_frame_index   = m_index_reg;
    assign m_evicted_valid = m_ev_valid_reg;
    assign m_evicted_page  = m_ev_page_reg;
    assign m_faults_so_far = m_fault_reg;

    // checks
    a_one_frame_chosen: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> $onehot(chosen_vec))
        else $error("update did not select exactly one frame");

    a_fill_in_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & (valid_vec + FRAMES'(1))) == '0)
        else $error("filled frames are not contiguous from frame zero");

    a_victim_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && ctrl.evict) |-> $onehot(victim_vec))
        else $error("eviction without a unique least recently used frame");

    a_fault_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> fault_reg >= $past(fault_reg))
        else $error("fault count went down");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> !$past(commit) || $past(m_valid_reg) == 1'b0)
        else $error("result overwritten while not taken");

endmodule : lru_page_replacement

`default_nettype wire
